// File: hdl/tgs_pkg.sv
// Shared types and constants for the trilinear grid sampler.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package tgs_pkg;

    // Default grid edge length (points per axis held in memory)
    localparam int DEF_MAX_DIM = 32;

    // Width of a widened cell index, enough to compare against any edge length
    localparam int CIDX_W = 9;
    // Width of a base cell index taken from the grid coordinate
    localparam int IDX_W  = 8;
    // Width of the configuration register index
    localparam int CFG_AW = 3;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [CFG_AW-1:0] {
        REG_SIZE_X      = 3'd0,
        REG_SIZE_Y      = 3'd1,
        REG_SIZE_Z      = 3'd2,
        REG_INV_SPACING = 3'd3,
        REG_ORIGIN_X    = 3'd4,
        REG_ORIGIN_Y    = 3'd5,
        REG_ORIGIN_Z    = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } axis_t;

    // Destination of one blend: four x-blends, two y-blends, one z-blend
    typedef enum logic [2:0] {
        TAG_X0 = 3'd0,
        TAG_X1 = 3'd1,
        TAG_X2 = 3'd2,
        TAG_X3 = 3'd3,
        TAG_Y0 = 3'd4,
        TAG_Y1 = 3'd5,
        TAG_Z  = 3'd6
    } blend_tag_t;

    typedef struct packed {
        logic               mode;
        logic [4:0]         cell_x;
        logic [4:0]         cell_y;
        logic [4:0]         cell_z;
        logic signed [31:0] cell_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               inside_res;
    } res_t;

    typedef struct packed {
        logic       load_item;
        logic       mem_write;
        logic       mul_en;
        axis_t      mul_axis;
        logic       chk_en;
        axis_t      chk_axis;
        logic       rd_en;
        logic [2:0] rd_corner;
        logic       cap_en;
        logic [2:0] cap_corner;
        logic       blend_go;
        blend_tag_t blend_tag;
        logic       out_load;
    } tgs_cmd_t;

    typedef struct packed {
        logic is_write;
        logic in_cube;
        logic out_free;
    } tgs_status_t;

endpackage

// File: hdl/tgs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: hdl/tgs_ctrl.sv
// Sequencer for the grid sampler: axis mapping, eight corner reads, blend order.
// Depends on tgs_pkg for the command and status structs.
`timescale 1ns / 1ps

module tgs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  tgs_pkg::tgs_status_t st,
    output tgs_pkg::tgs_cmd_t    cmd
);

    import tgs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MAP   = 5'b00010,
        S_FETCH = 5'b00100,
        S_BLEND = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [3:0] cnt_prev;

    assign cnt_prev  = 4'(cnt_reg - 4'd1);
    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.mul_axis   = axis_t'(cnt_reg[1:0]);
        cmd.chk_axis   = axis_t'(cnt_prev[1:0]);
        cmd.rd_corner  = cnt_reg[2:0];
        cmd.cap_corner = cnt_prev[2:0];
        cmd.blend_tag  = TAG_Y0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    cnt_next      = 4'd0;
                    state_next    = S_MAP;
                end
            end
            S_MAP:
            begin
                if (st.is_write)
                begin
                    cmd.mem_write = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    // multiply one axis, check the previous one
                    cmd.mul_en = (cnt_reg < 4'd3);
                    cmd.chk_en = (cnt_reg >= 4'd1);
                    if (cnt_reg == 4'd3)
                    begin
                        cnt_next   = 4'd0;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        cnt_next = 4'(cnt_reg + 4'd1);
                    end
                end
            end
            S_FETCH:
            begin
                if ((cnt_reg == 4'd0) && !st.in_cube)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // read corner n and capture corner n-1, which was read in the cycle before
                    cmd.rd_en  = (cnt_reg < 4'd8);
                    cmd.cap_en = (cnt_reg >= 4'd1);
                    if (cnt_reg == 4'd8)
                    begin
                        cnt_next   = 4'd0;
                        state_next = S_BLEND;
                    end
                    else
                    begin
                        cnt_next = 4'(cnt_reg + 4'd1);
                    end
                end
            end
            S_BLEND:
            begin
                case (cnt_reg)
                    4'd0:
                    begin
                        cmd.blend_go  = 1'b1;
                        cmd.blend_tag = TAG_Y0;
                    end
                    4'd1:
                    begin
                        cmd.blend_go  = 1'b1;
                        cmd.blend_tag = TAG_Y1;
                    end
                    4'd3:
                    begin
                        cmd.blend_go  = 1'b1;
                        cmd.blend_tag = TAG_Z;
                    end
                    default:
                    begin
                        cmd.blend_go = 1'b0;
                    end
                endcase
                if (cnt_reg == 4'd4)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = 4'(cnt_reg + 4'd1);
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hdl/tgs_dp.sv
// Datapath of the grid sampler: config registers, axis mapper, grid memory,
// two-stage blend unit and output register. Depends on tgs_pkg and tgs_ram.
`timescale 1ns / 1ps

module tgs_dp #(
    parameter int MAX_DIM = tgs_pkg::DEF_MAX_DIM
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tgs_pkg::req_t             req_data,
    input  logic                      cfg_we,
    input  logic [tgs_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [31:0]               cfg_wdata,
    output logic                      res_valid,
    input  logic                      res_stall,
    output tgs_pkg::res_t             res_data,
    input  tgs_pkg::tgs_cmd_t          cmd,
    output tgs_pkg::tgs_status_t       st
);

    import tgs_pkg::*;

    localparam int AW    = $clog2(MAX_DIM);
    localparam int DEPTH = 1 << (3 * AW);
    localparam logic [CIDX_W-1:0] MAXD = CIDX_W'(MAX_DIM);

    // configuration
    logic [5:0]         size_x_reg, size_y_reg, size_z_reg;
    logic [31:0]        inv_reg;
    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg;

    req_t item_reg;

    // axis mapping
    logic signed [31:0] pos_sel, org_sel;
    logic signed [32:0] offs;
    logic [63:0]        mul_c;
    logic [63:0]        prod_reg;
    logic               neg_reg;
    logic [5:0]         size_sel;
    logic [CIDX_W-1:0]  n_eff, n_lim;
    logic [31:0]        idx_full;
    logic               axis_ok;
    logic [IDX_W-1:0]   idx_reg [3];
    logic [15:0]        frac_reg [3];
    logic [2:0]         ok_reg;

    // memory
    logic [CIDX_W-1:0]  wx, wy, wz, rx, ry, rz;
    logic               wr_in_range;
    logic               ram_en, ram_we;
    logic [3*AW-1:0]    ram_addr;
    logic [31:0]        ram_rdata;

    // blend unit
    logic signed [31:0] lo_reg;
    logic               b_go;
    blend_tag_t         b_tag;
    logic signed [31:0] b_a, b_b;
    logic [15:0]        b_t;
    logic signed [32:0] b_diff;
    logic signed [49:0] b_prod;
    logic signed [49:0] bprod_reg;
    logic signed [31:0] bbase_reg;
    blend_tag_t         btag_reg;
    logic               bv_reg;
    logic signed [51:0] b_sum;
    logic signed [35:0] b_sh;
    logic signed [31:0] b_res;
    logic signed [31:0] acc_reg [7];

    res_t res_next;
    logic res_valid_reg;
    res_t res_data_reg;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 6'd32;
            size_y_reg <= 6'd32;
            size_z_reg <= 6'd32;
            inv_reg    <= 32'h0001_0000;
            org_x_reg  <= '0;
            org_y_reg  <= '0;
            org_z_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SIZE_X:      size_x_reg <= cfg_wdata[5:0];
                REG_SIZE_Y:      size_y_reg <= cfg_wdata[5:0];
                REG_SIZE_Z:      size_z_reg <= cfg_wdata[5:0];
                REG_INV_SPACING: inv_reg    <= cfg_wdata;
                REG_ORIGIN_X:    org_x_reg  <= cfg_wdata;
                REG_ORIGIN_Y:    org_y_reg  <= cfg_wdata;
                REG_ORIGIN_Z:    org_z_reg  <= cfg_wdata;
                default:         inv_reg    <= inv_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req_data;
        end
    end

    // ---------------- axis mapping ----------------
    always_comb
    begin
        case (cmd.mul_axis)
            AX_X:
            begin
                pos_sel = item_reg.pos_x;
                org_sel = org_x_reg;
            end
            AX_Y:
            begin
                pos_sel = item_reg.pos_y;
                org_sel = org_y_reg;
            end
            AX_Z:
            begin
                pos_sel = item_reg.pos_z;
                org_sel = org_z_reg;
            end
            default:
            begin
                pos_sel = item_reg.pos_x;
                org_sel = org_x_reg;
            end
        endcase
    end

    assign offs  = {pos_sel[31], pos_sel} - {org_sel[31], org_sel};
    // a negative offset only matters when the spacing register is nonzero;
    // with zero spacing the product below is zero anyway
    assign mul_c = offs[31:0] * inv_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_c;
            neg_reg  <= offs[32] && (inv_reg != 32'd0);
        end
    end

    always_comb
    begin
        case (cmd.chk_axis)
            AX_X:    size_sel = size_x_reg;
            AX_Y:    size_sel = size_y_reg;
            AX_Z:    size_sel = size_z_reg;
            default: size_sel = size_x_reg;
        endcase
    end

    assign n_eff    = (CIDX_W'(size_sel) > MAXD) ? MAXD : CIDX_W'(size_sel);
    assign n_lim    = CIDX_W'(n_eff - CIDX_W'(1));
    assign idx_full = prod_reg[63:32];
    assign axis_ok  = (n_eff >= CIDX_W'(2)) && !neg_reg && (idx_full < 32'(n_lim));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= '0;
        end
        else if (cmd.chk_en)
        begin
            ok_reg[cmd.chk_axis] <= axis_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.chk_en)
        begin
            idx_reg[cmd.chk_axis]  <= idx_full[IDX_W-1:0];
            frac_reg[cmd.chk_axis] <= prod_reg[31:16];
        end
    end

    // ---------------- grid memory ----------------
    assign wx = CIDX_W'(item_reg.cell_x);
    assign wy = CIDX_W'(item_reg.cell_y);
    assign wz = CIDX_W'(item_reg.cell_z);
    assign wr_in_range = (wx < MAXD) && (wy < MAXD) && (wz < MAXD);

    assign rx = CIDX_W'(idx_reg[AX_X]) + CIDX_W'(cmd.rd_corner[0]);
    assign ry = CIDX_W'(idx_reg[AX_Y]) + CIDX_W'(cmd.rd_corner[1]);
    assign rz = CIDX_W'(idx_reg[AX_Z]) + CIDX_W'(cmd.rd_corner[2]);

    assign ram_we   = cmd.mem_write && wr_in_range;
    assign ram_en   = ram_we || cmd.rd_en;
    assign ram_addr = cmd.mem_write ? {wz[AW-1:0], wy[AW-1:0], wx[AW-1:0]}
                                    : {rz[AW-1:0], ry[AW-1:0], rx[AW-1:0]};

    tgs_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item_reg.cell_value),
        .rdata (ram_rdata)
    );

    // ---------------- blend unit ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.cap_en && !cmd.cap_corner[0])
        begin
            lo_reg <= ram_rdata;
        end
    end

    // odd corners pair with the held even corner for an x-blend
    assign b_go = cmd.blend_go || (cmd.cap_en && cmd.cap_corner[0]);

    always_comb
    begin
        if (cmd.cap_en)
        begin
            b_tag = blend_tag_t'({1'b0, cmd.cap_corner[2:1]});
        end
        else
        begin
            b_tag = cmd.blend_tag;
        end
        case (b_tag)
            TAG_Y0:
            begin
                b_a = acc_reg[TAG_X0];
                b_b = acc_reg[TAG_X1];
                b_t = frac_reg[AX_Y];
            end
            TAG_Y1:
            begin
                b_a = acc_reg[TAG_X2];
                b_b = acc_reg[TAG_X3];
                b_t = frac_reg[AX_Y];
            end
            TAG_Z:
            begin
                b_a = acc_reg[TAG_Y0];
                b_b = acc_reg[TAG_Y1];
                b_t = frac_reg[AX_Z];
            end
            default:
            begin
                b_a = lo_reg;
                b_b = ram_rdata;
                b_t = frac_reg[AX_X];
            end
        endcase
    end

    // (1-t)*a + t*b == a + t*(b-a)
    assign b_diff = {b_b[31], b_b} - {b_a[31], b_a};
    assign b_prod = $signed({1'b0, b_t}) * b_diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= 1'b0;
        end
        else
        begin
            bv_reg <= b_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            bprod_reg <= b_prod;
            bbase_reg <= b_a;
            btag_reg  <= b_tag;
        end
    end

    // round half up, then floor by dropping the fraction
    assign b_sum = $signed({{4{bbase_reg[31]}}, bbase_reg, 16'h0000})
                 + $signed({{2{bprod_reg[49]}}, bprod_reg})
                 + 52'sd32768;
    assign b_sh  = b_sum[51:16];

    always_comb
    begin
        if (b_sh > 36'sd2147483647)
        begin
            b_res = 32'sh7FFF_FFFF;
        end
        else if (b_sh < -36'sd2147483648)
        begin
            b_res = 32'sh8000_0000;
        end
        else
        begin
            b_res = b_sh[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bv_reg)
        begin
            acc_reg[btag_reg] <= b_res;
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        res_next.inside_res   = (item_reg.mode == MODE_SAMPLE) && (&ok_reg);
        res_next.sample_value = res_next.inside_res ? acc_reg[TAG_Z] : 32'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_data_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    assign st.is_write = (item_reg.mode == MODE_WRITE);
    assign st.in_cube  = &ok_reg;
    assign st.out_free = !res_valid_reg || !res_stall;

endmodule

// File: hdl/trilinear_grid_sampler_top.sv
// A write request passes the map and done states; a sample outside the grid also runs
// the axis mapping and ends at fetch; an interior sample adds eight reads and the blends.
// One request at a time; the next is accepted the cycle after the result is loaded, and
// loading waits while the receiver stalls; the pace is set by the eight reads of the
// single-port grid memory and the shared multiplier and blend unit.
// Reset (rst_n, async) clears control state and loads config defaults; grid is not cleared.
`timescale 1ns / 1ps

module trilinear_grid_sampler_top #(
    parameter int MAX_DIM = tgs_pkg::DEF_MAX_DIM
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  tgs_pkg::req_t             req_data,
    output logic                      res_valid,
    input  logic                      res_stall,
    output tgs_pkg::res_t             res_data,
    input  logic                      cfg_we,
    input  logic [tgs_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [31:0]               cfg_wdata
);

    import tgs_pkg::*;

    tgs_cmd_t    cmd;
    tgs_status_t st;

    tgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd)
    );

    tgs_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// File: tb/sv/tb_trilinear_grid_sampler_top.sv
// Self-checking testbench for trilinear_grid_sampler_top: directed table, then random
// grid configurations with corner writes ahead of interior samples, bursty sender, stalling receiver.
// Depends on tgs_pkg and the top level only.
`timescale 1ns / 1ps

module tb_trilinear_grid_sampler_top;
    import tgs_pkg::*;

    typedef longint unsigned u64_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

    typedef struct {
        bit          is_reg;
        cfg_reg_t    reg_sel;
        logic [31:0] reg_val;
        req_t        req;
        bit          fixed;
        res_t        want;
    } step_t;

    typedef struct {
        req_t req;
        bit   fixed;
        res_t want;
    } send_t;

    localparam logic [31:0] SMAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] SMIN       = 32'h8000_0000;
    localparam logic [31:0] ONE_Q      = 32'h0001_0000;
    localparam logic [31:0] HALF_Q     = 32'h0000_8000;
    localparam longint      SAT_HI     = 64'sd2147483647;
    localparam longint      SAT_LO     = -64'sd2147483648;
    localparam int          NUM_PHASES = 8;
    localparam int          PHASE_REQS = 180;
    localparam int          CYCLE_LIMIT = 600_000;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req_data = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res_data;
    logic        cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    // shadow of the block: grid contents and register settings
    logic signed [31:0] grid_shadow [0:32767];
    bit                 planned [0:32767];
    logic [5:0]         size_q [3];
    logic [31:0]        spacing_q;
    logic signed [31:0] origin_q [3];

    send_t outbound [$];
    res_t  expected_answers [$];
    int    unsent = 0;
    int    queued = 0;
    int    writes_sent = 0;
    int    samples_sent = 0;
    int    results_seen = 0;
    int    inside_seen = 0;
    int    mismatches = 0;
    int    cycles = 0;

    send_t        slot;
    bit           cur_fixed;
    res_t         cur_want;
    res_t         pred_ans;
    res_t         got_want;
    int           burst_left = 1;
    int           gap_left = 0;
    int           stall_clock = 0;
    stall_style_t stall_style = STALL_NONE;

    trilinear_grid_sampler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_size(input int ax);
        return (size_q[ax] > 6'd32) ? 32 : int'(size_q[ax]);
    endfunction

    // grid coordinate along one axis; 0 when the point is outside the interior
    function automatic bit locate(input int ax, input logic signed [31:0] pos,
                                  output logic [4:0] idx, output logic [15:0] frac);
        longint d;
        u64_t   g;
        u64_t   lim;
        int     n;
        idx = '0;
        frac = '0;
        n = eff_size(ax);
        if (n < 2)
            return 0;
        d = longint'(pos) - longint'(origin_q[ax]);
        if (d < 0)
        begin
            if (spacing_q != 0)
                return 0;
            g = 0;
        end
        else
            g = (u64_t'(d) * u64_t'(spacing_q)) >> 16;
        lim = u64_t'(n - 1) << 16;
        if (g >= lim)
            return 0;
        idx = g[20:16];
        frac = g[15:0];
        return 1;
    endfunction

    function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [15:0] t);
        longint s;
        s = (longint'(65536) - longint'(t)) * longint'(a) + longint'(t) * longint'(b);
        s = (s + 32768) >>> 16;
        if (s > SAT_HI)
            return SMAX;
        if (s < SAT_LO)
            return SMIN;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] cell_at(input logic [4:0] x, input logic [4:0] y,
                                                   input logic [4:0] z);
        return grid_shadow[{z, y, x}];
    endfunction

    // expected answer for one request; a cell write also updates the shadow grid
    function automatic res_t sample_grid(input req_t r);
        res_t               ans;
        logic [4:0]         ix, iy, iz;
        logic [15:0]        tx, ty, tz;
        logic signed [31:0] c00, c10, c01, c11, p0, p1;
        ans = '0;
        if (r.mode == MODE_WRITE)
        begin
            grid_shadow[{r.cell_z, r.cell_y, r.cell_x}] = r.cell_value;
            return ans;
        end
        if (!locate(0, r.pos_x, ix, tx) || !locate(1, r.pos_y, iy, ty) ||
            !locate(2, r.pos_z, iz, tz))
            return ans;
        c00 = lerp(cell_at(ix, iy, iz), cell_at(ix + 5'd1, iy, iz), tx);
        c10 = lerp(cell_at(ix, iy + 5'd1, iz), cell_at(ix + 5'd1, iy + 5'd1, iz), tx);
        c01 = lerp(cell_at(ix, iy, iz + 5'd1), cell_at(ix + 5'd1, iy, iz + 5'd1), tx);
        c11 = lerp(cell_at(ix, iy + 5'd1, iz + 5'd1),
                   cell_at(ix + 5'd1, iy + 5'd1, iz + 5'd1), tx);
        p0 = lerp(c00, c10, ty);
        p1 = lerp(c01, c11, ty);
        ans.sample_value = lerp(p0, p1, tz);
        ans.inside_res = 1'b1;
        return ans;
    endfunction

    function automatic logic [31:0] rand_cell_value();
        case ($urandom_range(0, 7))
            0: return SMAX;
            1: return SMIN;
            2: return '0;
            3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t cell_write(input logic [4:0] x, input logic [4:0] y,
                                        input logic [4:0] z, input logic [31:0] v);
        req_t r;
        r.mode = MODE_WRITE;
        r.cell_x = x;
        r.cell_y = y;
        r.cell_z = z;
        r.cell_value = v;
        r.pos_x = $urandom;
        r.pos_y = $urandom;
        r.pos_z = $urandom;
        return r;
    endfunction

    // world position whose grid coordinate lands near a chosen point, edges included
    function automatic logic [31:0] aim_at(input int ax);
        u64_t lim;
        u64_t goal;
        u64_t d;
        int   n;
        n = eff_size(ax);
        if (n < 2 || spacing_q == 0)
            return $urandom;
        lim = u64_t'(n - 1) << 16;
        case ($urandom_range(0, 7))
            0: goal = 0;
            1: goal = lim - 1;
            2: goal = lim;
            default: goal = u64_t'($urandom_range(0, 32'(lim - 1)));
        endcase
        d = ((goal << 16) + spacing_q - 1) / spacing_q;
        return origin_q[ax] + d[31:0];
    endfunction

    function automatic step_t wr_step(input logic [4:0] x, input logic [4:0] y,
                                      input logic [4:0] z, input logic [31:0] v);
        step_t st;
        st = '{default: '0, reg_sel: REG_SIZE_X};
        st.req = cell_write(x, y, z, v);
        st.fixed = 1'b1;
        return st;
    endfunction

    function automatic step_t probe_step(input logic [31:0] px, input logic [31:0] py,
                                         input logic [31:0] pz, input bit fixed,
                                         input logic [31:0] val, input logic in_flag);
        step_t st;
        st = '{default: '0, reg_sel: REG_SIZE_X};
        st.req.mode = MODE_SAMPLE;
        st.req.pos_x = px;
        st.req.pos_y = py;
        st.req.pos_z = pz;
        st.fixed = fixed;
        st.want.sample_value = val;
        st.want.inside_res = in_flag;
        return st;
    endfunction

    function automatic step_t reg_step(input cfg_reg_t sel, input logic [31:0] v);
        step_t st;
        st = '{default: '0, reg_sel: REG_SIZE_X};
        st.is_reg = 1'b1;
        st.reg_sel = sel;
        st.reg_val = v;
        return st;
    endfunction

    task automatic queue_req(input req_t r, input bit fixed, input res_t want);
        send_t s;
        s.req = r;
        s.fixed = fixed;
        s.want = want;
        outbound.push_back(s);
        if (r.mode == MODE_WRITE)
            planned[{r.cell_z, r.cell_y, r.cell_x}] = 1'b1;
        unsent++;
        queued++;
    endtask

    // sample request; write any corner not yet written (and some at random) first
    task automatic plan_probe(input bit aimed);
        req_t       r;
        logic [4:0] i, j, k;
        logic [4:0] cx, cy, cz;
        logic [15:0] f;
        bit         hit;
        r.mode = MODE_SAMPLE;
        r.cell_x = 5'($urandom_range(0, 31));
        r.cell_y = 5'($urandom_range(0, 31));
        r.cell_z = 5'($urandom_range(0, 31));
        r.cell_value = $urandom;
        r.pos_x = aimed ? aim_at(0) : $urandom;
        r.pos_y = aimed ? aim_at(1) : $urandom;
        r.pos_z = aimed ? aim_at(2) : $urandom;
        hit = locate(0, r.pos_x, i, f) && locate(1, r.pos_y, j, f) && locate(2, r.pos_z, k, f);
        if (hit)
        begin
            for (int c = 0; c < 8; c++)
            begin
                cx = i + 5'(c[0]);
                cy = j + 5'(c[1]);
                cz = k + 5'(c[2]);
                if (!planned[{cz, cy, cx}] || $urandom_range(0, 5) == 0)
                    queue_req(cell_write(cx, cy, cz, rand_cell_value()), 1'b0, '0);
            end
        end
        queue_req(r, 1'b0, '0);
    endtask

    task automatic set_reg(input cfg_reg_t sel, input logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= sel;
        cfg_wdata <= v;
        case (sel)
            REG_SIZE_X:      size_q[0] = v[5:0];
            REG_SIZE_Y:      size_q[1] = v[5:0];
            REG_SIZE_Z:      size_q[2] = v[5:0];
            REG_INV_SPACING: spacing_q = v;
            REG_ORIGIN_X:    origin_q[0] = v;
            REG_ORIGIN_Y:    origin_q[1] = v;
            REG_ORIGIN_Z:    origin_q[2] = v;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // block is idle once every request went out and every answer came back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (unsent != 0 || expected_answers.size() != 0);
        repeat (25) @(posedge clk);
    endtask

    // sender: bursts of requests separated by random gaps; hold while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                pred_ans = sample_grid(req_data);
                expected_answers.push_back(cur_fixed ? cur_want : pred_ans);
                unsent--;
                if (req_data.mode == MODE_WRITE)
                    writes_sent++;
                else
                    samples_sent++;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (outbound.size() > 0)
                begin
                    slot = outbound.pop_front();
                    req_data <= slot.req;
                    cur_fixed = slot.fixed;
                    cur_want = slot.want;
                    req_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver: compare each answer with the oldest expectation, stall by its own pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (res_data.inside_res === 1'b1)
                    inside_seen++;
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing pending: value %h inside %b",
                                 results_seen, res_data.sample_value, res_data.inside_res);
                end
                else
                begin
                    got_want = expected_answers.pop_front();
                    if (res_data.sample_value !== got_want.sample_value ||
                        res_data.inside_res !== got_want.inside_res)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %h/%b, got %h/%b",
                                     results_seen, got_want.sample_value, got_want.inside_res,
                                     res_data.sample_value, res_data.inside_res);
                    end
                end
            end
            stall_clock++;
            if (stall_clock % 300 == 0)
                stall_style = stall_style_t'($urandom_range(0, 3));
            case (stall_style)
                STALL_NONE:  res_stall <= 1'b0;
                STALL_LIGHT: res_stall <= ($urandom_range(0, 2) == 0);
                STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
                default:     res_stall <= (stall_clock % 16 < 6);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_trilinear_grid_sampler_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        step_t              steps [$];
        logic [5:0]         sz [3];
        logic [31:0]        spacing;
        logic [31:0]        org [3];
        int                 phase_end;

        size_q = '{6'd32, 6'd32, 6'd32};
        spacing_q = ONE_Q;
        origin_q = '{32'd0, 32'd0, 32'd0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // cube at the origin holds the largest value, so inside answers are exact
        for (int c = 0; c < 8; c++)
            steps.push_back(wr_step(5'(c[0]), 5'(c[1]), 5'(c[2]), SMAX));
        steps.push_back(wr_step(5'd31, 5'd31, 5'd31, SMIN));
        steps.push_back(probe_step(0, 0, 0, 1, SMAX, 1));
        steps.push_back(probe_step(HALF_Q, HALF_Q, HALF_Q, 1, SMAX, 1));
        steps.push_back(probe_step(32'hFFFF_FFFF, 0, 0, 1, 0, 0));
        steps.push_back(probe_step(SMAX, 0, 0, 1, 0, 0));
        steps.push_back(probe_step(0, SMIN, 0, 1, 0, 0));
        steps.push_back(probe_step(0, 0, 32'd31 << 16, 1, 0, 0));
        // empty interior, then a size beyond the grid edge
        steps.push_back(reg_step(REG_SIZE_X, 32'd1));
        steps.push_back(probe_step(HALF_Q, HALF_Q, HALF_Q, 1, 0, 0));
        steps.push_back(reg_step(REG_SIZE_X, 32'd63));
        steps.push_back(reg_step(REG_SIZE_Y, 32'd2));
        steps.push_back(probe_step(HALF_Q, HALF_Q, HALF_Q, 1, SMAX, 1));
        steps.push_back(probe_step(0, ONE_Q, 0, 1, 0, 0));
        steps.push_back(reg_step(REG_SIZE_Z, 32'd33));
        steps.push_back(probe_step(0, 0, HALF_Q, 1, SMAX, 1));
        // zero spacing pins every sample to the origin cell
        steps.push_back(reg_step(REG_INV_SPACING, 32'd0));
        steps.push_back(probe_step(SMIN, SMIN, SMIN, 1, SMAX, 1));
        steps.push_back(probe_step(SMAX, SMAX, SMAX, 1, SMAX, 1));
        steps.push_back(reg_step(REG_INV_SPACING, 32'hFFFF_FFFF));
        steps.push_back(reg_step(REG_ORIGIN_X, SMAX));
        steps.push_back(reg_step(REG_ORIGIN_Y, SMIN));
        steps.push_back(reg_step(REG_ORIGIN_Z, 32'hFFFF_0000));
        steps.push_back(probe_step(SMAX, SMIN, 32'hFFFF_0000, 1, SMAX, 1));
        steps.push_back(probe_step(SMIN, SMIN, 32'hFFFF_0000, 1, 0, 0));
        steps.push_back(reg_step(REG_SIZE_X, 32'd32));
        steps.push_back(reg_step(REG_SIZE_Y, 32'd32));
        steps.push_back(reg_step(REG_SIZE_Z, 32'd32));
        steps.push_back(reg_step(REG_INV_SPACING, ONE_Q));
        steps.push_back(reg_step(REG_ORIGIN_X, 32'd0));
        steps.push_back(reg_step(REG_ORIGIN_Y, 32'd0));
        steps.push_back(reg_step(REG_ORIGIN_Z, 32'd0));
        steps.push_back(wr_step(5'd1, 5'd0, 5'd0, 32'hFFFF_0000));
        steps.push_back(probe_step(32'h0000_4000, 32'h0000_C000, HALF_Q, 0, 0, 0));

        foreach (steps[s])
        begin
            if (steps[s].is_reg)
            begin
                wait_idle();
                set_reg(steps[s].reg_sel, steps[s].reg_val);
            end
            else
                queue_req(steps[s].req, steps[s].fixed, steps[s].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                case ($urandom_range(0, 9))
                    0: sz[a] = 6'd2;
                    1: sz[a] = 6'd32;
                    2: sz[a] = 6'($urandom_range(0, 1));
                    3: sz[a] = 6'($urandom_range(33, 63));
                    default: sz[a] = 6'($urandom_range(2, 32));
                endcase
                if (p == 0)
                    sz[a] = 6'd32;
                else if (p == 1)
                    sz[a] = 6'd2;
                if ($urandom_range(0, 3) == 0)
                    org[a] = $urandom;
                else
                    org[a] = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
                if (p == 1)
                    org[a] = SMIN;
                else if (p == 3)
                    org[a] = SMAX;
            end
            case (p)
                0: spacing = ONE_Q;
                1: spacing = 32'd1;
                2: spacing = 32'hFFFF_FFFF;
                3: spacing = 32'd0;
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: spacing = $urandom;
                        1: spacing = 32'd1 << $urandom_range(10, 20);
                        default: spacing = $urandom_range(32'h0000_4000, 32'h0004_0000);
                    endcase
                end
            endcase

            wait_idle();
            set_reg(REG_SIZE_X, 32'(sz[0]));
            set_reg(REG_SIZE_Y, 32'(sz[1]));
            set_reg(REG_SIZE_Z, 32'(sz[2]));
            set_reg(REG_INV_SPACING, spacing);
            set_reg(REG_ORIGIN_X, org[0]);
            set_reg(REG_ORIGIN_Y, org[1]);
            set_reg(REG_ORIGIN_Z, org[2]);

            phase_end = queued + PHASE_REQS;
            while (queued < phase_end)
            begin
                case ($urandom_range(0, 9))
                    7: queue_req(cell_write(5'($urandom_range(0, 31)),
                                            5'($urandom_range(0, 31)),
                                            5'($urandom_range(0, 31)), rand_cell_value()),
                                 1'b0, '0);
                    8, 9: plan_probe(1'b0);
                    default: plan_probe(1'b1);
                endcase
            end
        end

        wait_idle();
        $display("Covered %0d requests: %0d cell writes, %0d samples (%0d inside the grid),",
                 writes_sent + samples_sent, writes_sent, samples_sent, inside_seen);
        $display("over the reset settings plus %0d random register settings; %0d errors",
                 NUM_PHASES, mismatches);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("tb_trilinear_grid_sampler_top OK");
        else
            $display("tb_trilinear_grid_sampler_top NOT OK");
        $finish;
    end

endmodule
